>>> rtl/multi_sensor_direction_hold_smoother_macros.svh
// assertion macros for the direction-hold smoother
// used by the top level, expects clk_i and rst_ni in scope
`ifndef MULTI_SENSOR_DIRECTION_HOLD_SMOOTHER_MACROS_SVH
`define MULTI_SENSOR_DIRECTION_HOLD_SMOOTHER_MACROS_SVH

// same-cycle implication
`define MSDHS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MSDHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/msdhs_pkg.sv
// shared types, codes and constants of the direction-hold smoother
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package msdhs_pkg;

  localparam int SENSOR_COUNT_DEF = 4;
  localparam int TEMP_W           = 8;
  localparam int CFG_W            = 16;
  localparam int TIMER_W          = 32;
  localparam int IDX_W            = 2;
  localparam int PC_W             = 3;

  localparam logic [CFG_W-1:0] HOLD_LIMIT_RESET       = CFG_W'(10 * 1000);
  localparam logic [CFG_W-1:0] PERIOD_INCREMENT_RESET = CFG_W'(1000);

  // configuration register indexes
  localparam logic CFG_HOLD_LIMIT = 1'b0;
  localparam logic CFG_PERIOD_INC = 1'b1;

  // input opcodes
  localparam logic OPC_STORE  = 1'b0;
  localparam logic OPC_UPDATE = 1'b1;

  // direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // microprogram steps
  localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [PC_W-1:0] STEP_ACC  = 3'd1;
  localparam logic [PC_W-1:0] STEP_ABS  = 3'd2;
  localparam logic [PC_W-1:0] STEP_MUL  = 3'd3;
  localparam logic [PC_W-1:0] STEP_MULN = 3'd4;
  localparam logic [PC_W-1:0] STEP_FIX  = 3'd5;
  localparam logic [PC_W-1:0] STEP_UPD  = 3'd6;
  localparam logic [PC_W-1:0] STEP_ERR  = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLR,
    OP_ACC,
    OP_ABS,
    OP_MUL,
    OP_MULN,
    OP_FIX,
    OP_UPD_ERR
  } op_e;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NO_START,
    JC_MORE,
    JC_FAULT
  } jcond_e;

  typedef struct packed {
    op_e             op;
    logic            err_path;
    jcond_e          jcond;
    logic [PC_W-1:0] target;
    logic            wait_out;
  } ctrl_t;

  typedef struct packed {
    logic more;
    logic fault;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic            idle;
    logic [PC_W-1:0] pc;
  } seq_stat_t;

endpackage

`default_nettype wire

>>> rtl/multi_sensor_direction_hold_smoother.sv
// Multi-sensor temperature averager with direction-hold smoothing.
// Input stream: a store beat (tuser opcode 0) writes one sensor's reading and
// fault flag and gives no result; an update beat (opcode 1) averages all
// sensors, truncating toward zero, and gives one result beat.
// Output stream: held temperature, direction, and an error flag in tuser.
// Configuration: write port for hold_limit (index 0) and period_increment
// (index 1); the user must write them only while the block is idle, which the block does not enforce.
// A store beat is written while the sequencer stays in its idle step. An
// update beat runs a microprogram: the accumulate step walks the sensors one
// per cycle, then magnitude, two multiply steps of the reciprocal divider,
// correction, and the hold update. A faulted update goes from the magnitude
// step to the error step instead. Input is taken only while the sequencer
// sits in its idle step.
// The result register lets a store beat in while a result waits; an update
// that finishes while the receiver stalls holds in its last step until the
// output slot frees up.
// Reset clears the sensor store, the held output, the direction and sets the
// hold timer and both registers to their defaults; no result is pending.
// depends on msdhs_pkg, msdhs_sequencer, msdhs_datapath and the macro header
`timescale 1ns / 1ps
`default_nettype none
`include "multi_sensor_direction_hold_smoother_macros.svh"

module multi_sensor_direction_hold_smoother
  import msdhs_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // sensor_index[1:0], reading[9:2], zero fill
  input  logic [1:0]       s_axis_tuser,   // opcode[0], reading_fault[1]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // smoothed_temp[7:0], direction[9:8], zero fill
  output logic             m_axis_tuser,   // smoothed_error
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [CFG_W-1:0]         hold_limit_q, hold_limit_d;
  logic [CFG_W-1:0]         period_inc_q, period_inc_d;
  logic                     accept;
  logic                     store;
  logic                     start;
  ctrl_t                    exec;
  seq_stat_t                seq;
  dp_stat_t                 stat;
  logic signed [TEMP_W-1:0] out_temp;
  logic [1:0]               out_dir;
  logic                     emit;

  assign s_axis_tready = seq.idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign store         = accept && (s_axis_tuser[0] == OPC_STORE);
  assign start         = accept && (s_axis_tuser[0] == OPC_UPDATE);

  always_comb begin
    hold_limit_d = hold_limit_q;
    period_inc_d = period_inc_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOLD_LIMIT: hold_limit_d = cfg_wdata_i;
        CFG_PERIOD_INC: period_inc_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_limit_q <= HOLD_LIMIT_RESET;
      period_inc_q <= PERIOD_INCREMENT_RESET;
    end else begin
      hold_limit_q <= hold_limit_d;
      period_inc_q <= period_inc_d;
    end
  end

  msdhs_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .exec_o (exec),
    .seq_o  (seq)
  );

  msdhs_datapath #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .store_i      (store),
    .store_idx_i  (s_axis_tdata[1:0]),
    .store_temp_i (s_axis_tdata[9:2]),
    .store_fault_i(s_axis_tuser[1]),
    .ctrl_i       (exec),
    .hold_limit_i (hold_limit_q),
    .period_inc_i (period_inc_q),
    .out_ready_i  (m_axis_tready),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_temp_o   (out_temp),
    .out_err_o    (m_axis_tuser),
    .out_dir_o    (out_dir)
  );

  assign m_axis_tdata = {6'b0, out_dir, out_temp};
  assign emit         = (exec.op == OP_UPD_ERR);

  `MSDHS_ASSERT_IMPL(a_valid_from_emit, $rose(m_axis_tvalid), $past(emit))
  `MSDHS_ASSERT_NEXT(a_update_starts_acc, start, seq.pc == STEP_ACC)
  `MSDHS_ASSERT_IMPL(a_error_temp_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[7:0] == 8'd0)
  `MSDHS_ASSERT_IMPL(a_no_emit_into_busy, stat.out_busy, !emit)

endmodule

`default_nettype wire

>>> rtl/msdhs_ucode_rom.sv
// microprogram table: one control word per step
// depends on msdhs_pkg
`timescale 1ns / 1ps
`default_nettype none

module msdhs_ucode_rom
  import msdhs_pkg::*;
(
  input  logic [PC_W-1:0] pc_i,
  output ctrl_t           word_o
);

  always_comb begin
    word_o = '{op: OP_NOP, err_path: 1'b0, jcond: JC_ALWAYS, target: STEP_IDLE,
               wait_out: 1'b0};
    case (pc_i)
      STEP_IDLE: begin
        word_o.op     = OP_CLR;
        word_o.jcond  = JC_NO_START;
        word_o.target = STEP_IDLE;
      end
      STEP_ACC: begin
        word_o.op     = OP_ACC;
        word_o.jcond  = JC_MORE;
        word_o.target = STEP_ACC;
      end
      STEP_ABS: begin
        word_o.op     = OP_ABS;
        word_o.jcond  = JC_FAULT;
        word_o.target = STEP_ERR;
      end
      STEP_MUL: begin
        word_o.op    = OP_MUL;
        word_o.jcond = JC_NONE;
      end
      STEP_MULN: begin
        word_o.op    = OP_MULN;
        word_o.jcond = JC_NONE;
      end
      STEP_FIX: begin
        word_o.op    = OP_FIX;
        word_o.jcond = JC_NONE;
      end
      STEP_UPD: begin
        word_o.op       = OP_UPD_ERR;
        word_o.wait_out = 1'b1;
      end
      STEP_ERR: begin
        word_o.op       = OP_UPD_ERR;
        word_o.err_path = 1'b1;
        word_o.wait_out = 1'b1;
      end
      default: begin
        word_o.op = OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/msdhs_sequencer.sv
// step counter with conditional jumps, fetches control words from the table
// depends on msdhs_pkg and msdhs_ucode_rom
`timescale 1ns / 1ps
`default_nettype none

module msdhs_sequencer
  import msdhs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_stat_t  stat_i,
  output ctrl_t     exec_o,
  output seq_stat_t seq_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            stall;
  logic            take;

  msdhs_ucode_rom u_rom (
    .pc_i  (pc_q),
    .word_o(word)
  );

  // hold the step while the result slot is still occupied
  assign stall = word.wait_out && stat_i.out_busy;

  always_comb begin
    case (word.jcond)
      JC_NONE:     take = 1'b0;
      JC_ALWAYS:   take = 1'b1;
      JC_NO_START: take = !start_i;
      JC_MORE:     take = stat_i.more;
      JC_FAULT:    take = stat_i.fault;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_comb begin
    exec_o = word;
    if (stall) begin
      exec_o.op = OP_NOP;
    end
  end

  assign seq_o.idle = (pc_q == STEP_IDLE);
  assign seq_o.pc   = pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/msdhs_datapath.sv
// sensor store, serial accumulator, reciprocal divider, hold logic and result register
// depends on msdhs_pkg
`timescale 1ns / 1ps
`default_nettype none

module msdhs_datapath
  import msdhs_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     store_i,
  input  logic [IDX_W-1:0]         store_idx_i,
  input  logic signed [TEMP_W-1:0] store_temp_i,
  input  logic                     store_fault_i,
  input  ctrl_t                    ctrl_i,
  input  logic [CFG_W-1:0]         hold_limit_i,
  input  logic [CFG_W-1:0]         period_inc_i,
  input  logic                     out_ready_i,
  output dp_stat_t                 stat_o,
  output logic                     out_valid_o,
  output logic signed [TEMP_W-1:0] out_temp_o,
  output logic                     out_err_o,
  output logic [1:0]               out_dir_o
);

  localparam int PTR_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int SUM_W   = TEMP_W + $clog2(SENSOR_COUNT);
  localparam int SH      = SUM_W;
  localparam int RECIP_W = SH + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SH) / SENSOR_COUNT);
  localparam logic [SUM_W-1:0]   N_V   = SUM_W'(SENSOR_COUNT);
  localparam logic [PTR_W-1:0]   LAST  = PTR_W'(SENSOR_COUNT - 1);

  logic signed [TEMP_W-1:0] temps_q [SENSOR_COUNT];
  logic signed [TEMP_W-1:0] temps_d [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0]  faults_q, faults_d;

  logic [PTR_W-1:0]         ptr_q, ptr_d;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic                     fault_q, fault_d;
  logic                     neg_q, neg_d;
  logic [SUM_W-1:0]         mag_q, mag_d;
  logic [TEMP_W-1:0]        q0_q, q0_d;
  logic [SUM_W-1:0]         qn_q, qn_d;
  logic signed [TEMP_W-1:0] avg_q, avg_d;

  logic signed [TEMP_W-1:0] held_temp_q, held_temp_d;
  logic                     held_err_q, held_err_d;
  logic [1:0]               held_dir_q, held_dir_d;
  logic [TIMER_W-1:0]       timer_q, timer_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [TEMP_W-1:0] out_temp_q, out_temp_d;
  logic                     out_err_q, out_err_d;
  logic [1:0]               out_dir_q, out_dir_d;

  logic [PROD_W-1:0]        prod;
  logic [SUM_W-1:0]         rem;
  logic [TEMP_W-1:0]        q_fix;
  logic [TIMER_W:0]         timer_sum;
  logic [TIMER_W-1:0]       limit_ext;
  logic                     gt, lt, moves;

  assign prod      = PROD_W'(mag_q) * PROD_W'(RECIP);
  assign rem       = mag_q - qn_q;
  assign q_fix     = (rem >= N_V) ? q0_q + 1'b1 : q0_q;
  assign limit_ext = TIMER_W'(hold_limit_i);
  assign timer_sum = {1'b0, timer_q} + (TIMER_W + 1)'(period_inc_i);
  assign gt        = avg_q > held_temp_q;
  assign lt        = avg_q < held_temp_q;
  assign moves     = (gt && held_dir_q == DIR_UP) || (lt && held_dir_q == DIR_DOWN) ||
                     (timer_q >= limit_ext && avg_q != held_temp_q);

  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      temps_d[i]  = temps_q[i];
      faults_d[i] = faults_q[i];
      if (store_i && (32'(store_idx_i) == i)) begin
        temps_d[i]  = store_temp_i;
        faults_d[i] = store_fault_i;
      end
    end
  end

  always_comb begin
    ptr_d       = ptr_q;
    acc_d       = acc_q;
    fault_d     = fault_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    q0_d        = q0_q;
    qn_d        = qn_q;
    avg_d       = avg_q;
    held_temp_d = held_temp_q;
    held_err_d  = held_err_q;
    held_dir_d  = held_dir_q;
    timer_d     = timer_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_temp_d  = out_temp_q;
    out_err_d   = out_err_q;
    out_dir_d   = out_dir_q;
    case (ctrl_i.op)
      OP_NOP: begin
      end
      OP_CLR: begin
        ptr_d   = '0;
        acc_d   = '0;
        fault_d = 1'b0;
      end
      OP_ACC: begin
        acc_d   = acc_q + SUM_W'(temps_q[ptr_q]);
        fault_d = fault_q | faults_q[ptr_q];
        ptr_d   = ptr_q + 1'b1;
      end
      OP_ABS: begin
        neg_d = acc_q[SUM_W-1];
        mag_d = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
      end
      OP_MUL: begin
        q0_d = prod[SH +: TEMP_W];
      end
      OP_MULN: begin
        qn_d = SUM_W'(SUM_W'(q0_q) * N_V);
      end
      OP_FIX: begin
        avg_d = neg_q ? TEMP_W'(-q_fix) : q_fix;
      end
      OP_UPD_ERR: begin
        out_valid_d = 1'b1;
        if (ctrl_i.err_path) begin
          held_err_d = 1'b1;
          out_temp_d = '0;
          out_err_d  = 1'b1;
          out_dir_d  = held_dir_q;
        end else begin
          if (held_err_q) begin
            held_temp_d = avg_q;
            timer_d     = limit_ext;
            held_err_d  = 1'b0;
          end else if (moves) begin
            held_dir_d  = gt ? DIR_UP : DIR_DOWN;
            held_temp_d = avg_q;
            timer_d     = '0;
          end else begin
            timer_d = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
          end
          out_temp_d = held_temp_d;
          out_err_d  = 1'b0;
          out_dir_d  = held_dir_d;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        temps_q[i] <= '0;
      end
      faults_q    <= '0;
      held_temp_q <= '0;
      held_err_q  <= 1'b0;
      held_dir_q  <= DIR_NONE;
      timer_q     <= TIMER_W'(HOLD_LIMIT_RESET);
      out_valid_q <= 1'b0;
    end else begin
      temps_q     <= temps_d;
      faults_q    <= faults_d;
      held_temp_q <= held_temp_d;
      held_err_q  <= held_err_d;
      held_dir_q  <= held_dir_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    acc_q      <= acc_d;
    fault_q    <= fault_d;
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    q0_q       <= q0_d;
    qn_q       <= qn_d;
    avg_q      <= avg_d;
    out_temp_q <= out_temp_d;
    out_err_q  <= out_err_d;
    out_dir_q  <= out_dir_d;
  end

  assign stat_o.more     = (ptr_q != LAST);
  assign stat_o.fault    = fault_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_temp_o  = out_temp_q;
  assign out_err_o   = out_err_q;
  assign out_dir_o   = out_dir_q;

endmodule

`default_nettype wire
